### rtl/srdv_pkg.sv
// ----------------------------------------------------------------------------
// srdv_pkg: shared types and constants for the sensor ring direction core
// Widths of the running sums, the CORDIC and root datapath, the arctangent
// table in degrees Q16, and the structs that travel along the cell chains.
// ----------------------------------------------------------------------------
package srdv_pkg;

    // Frame and result field widths
    localparam int BITS_W      = 32;
    localparam int TRIM_W      = 9;
    localparam int THR_W       = 12;
    localparam int MAG_W       = 12;
    localparam int DIR_W       = 9;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 1;

    // Datapath widths
    localparam int UNIT_W       = 16;  // Q1.14 unit vector component
    localparam int SUM_W        = 21;  // signed sum of up to 32 components
    localparam int ABS_W        = 20;  // magnitude of one sum
    localparam int SQ_W         = 40;  // X*X + Y*Y
    localparam int ROOT_W       = 20;  // floor square root of SQ_W bits
    localparam int CORDIC_STEPS = 20;
    localparam int CX_W         = 33;  // CORDIC x and y
    localparam int Z_W          = 25;  // angle in degrees Q16
    localparam int V_W          = 26;  // trim minus angle, degrees Q16
    localparam int DEG_W        = 10;  // whole degrees before wrapping

    localparam int CORDIC_PRESHIFT = 10;
    localparam int FRAC_SHIFT      = 16;
    localparam int MAG_SHIFT       = 6;

    localparam logic [V_W-1:0] FRAC_MASK = V_W'(65535);
    localparam logic [MAG_W-1:0] MAG_MAX = 12'd4095;

    localparam logic signed [Z_W-1:0] DEG45_Q16  = 25'sd2949120;
    localparam logic signed [Z_W-1:0] DEG90_Q16  = 25'sd5898240;
    localparam logic signed [Z_W-1:0] DEG180_Q16 = 25'sd11796480;

    localparam logic signed [DEG_W-1:0] DIR_LIMIT = 10'sd180;
    localparam logic signed [DEG_W-1:0] DEG_TURN  = 10'sd360;

    localparam logic signed [TRIM_W-1:0] TRIM_RESET      = 9'sd5;
    localparam logic [THR_W-1:0]         THRESHOLD_RESET = 12'd0;

    // Unit vector table generation, Q30
    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned PI_Q30  = 64'd3373259426;

    // atan(2^-i) in degrees Q16
    localparam logic signed [Z_W-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234378,
        25'sd117303,  25'sd58666,   25'sd29335,  25'sd14668,  25'sd7334,
        25'sd3667,    25'sd1833,    25'sd917,    25'sd458,    25'sd229,
        25'sd115,     25'sd57,      25'sd29,     25'sd14,     25'sd7
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ANGLE_TRIM    = 1'b0,
        CFG_FAR_THRESHOLD = 1'b1
    } cfg_index_t;

    // How the first-quadrant angle is found
    typedef enum logic [2:0] {
        ANG_CORDIC = 3'd0,
        ANG_ZERO   = 3'd1,
        ANG_ON_X   = 3'd2,
        ANG_ON_Y   = 3'd3,
        ANG_DIAG   = 3'd4
    } angle_case_t;

    typedef struct packed {
        logic [BITS_W-1:0]       bits;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
    } sum_data_t;

    typedef struct packed {
        logic      valid;
        sum_data_t data;
    } sum_stage_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [SQ_W-1:0]        rem;
        logic [ROOT_W-1:0]      root;
        logic                   sx_neg;
        logic                   sy_neg;
        angle_case_t            acase;
    } vec_data_t;

    typedef struct packed {
        logic      valid;
        vec_data_t data;
    } vec_stage_t;

endpackage

### rtl/srdv_sum_cell.sv
// ----------------------------------------------------------------------------
// srdv_sum_cell: one sensor of the ring
// Adds the fixed unit vector of its sensor to the running sums when the
// sensor bit is low, then hands the frame on to the next cell.
// ----------------------------------------------------------------------------
module srdv_sum_cell #(
    parameter int SENSOR_COUNT = 32,
    parameter int INDEX        = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  srdv_pkg::sum_stage_t stage_in,
    output srdv_pkg::sum_stage_t stage_out
);
    import srdv_pkg::*;

    // Sin or cos of this sensor's angle, rounded to Q1.14
    function automatic longint unit_coord(input bit want_sin);
        longint q;
        longint m;
        longint si;
        longint ci;
        longint c_out;
        longint s_out;
        longint unsigned am;
        longint unsigned x;
        longint unsigned u;
        longint unsigned t;
        longint unsigned s;
        longint unsigned c;
        q  = (8 * INDEX + SENSOR_COUNT) / 2 / SENSOR_COUNT;
        m  = 4 * INDEX - q * SENSOR_COUNT;
        am = (m < 0) ? -m : m;
        x  = PI_Q30 * am / 2 / SENSOR_COUNT;
        u  = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((u * t) >> 30) / 110;
        t  = Q30_ONE - ((u * t) >> 30) / 72;
        t  = Q30_ONE - ((u * t) >> 30) / 42;
        t  = Q30_ONE - ((u * t) >> 30) / 20;
        t  = Q30_ONE - ((u * t) >> 30) / 6;
        s  = (x * t) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((u * t) >> 30) / 132;
        t  = Q30_ONE - ((u * t) >> 30) / 90;
        t  = Q30_ONE - ((u * t) >> 30) / 56;
        t  = Q30_ONE - ((u * t) >> 30) / 30;
        t  = Q30_ONE - ((u * t) >> 30) / 12;
        c  = Q30_ONE - ((u * t) >> 30) / 2;
        si = longint'((s + 64'd32768) >> 16);
        ci = longint'((c + 64'd32768) >> 16);
        if (m < 0)
        begin
            si = -si;
        end
        unique case (q & 3)
            0:
            begin
                c_out = ci;
                s_out = si;
            end
            1:
            begin
                c_out = -si;
                s_out = ci;
            end
            2:
            begin
                c_out = -ci;
                s_out = -si;
            end
            default:
            begin
                c_out = si;
                s_out = -ci;
            end
        endcase
        return want_sin ? s_out : c_out;
    endfunction

    localparam logic signed [UNIT_W-1:0] COS_K = UNIT_W'(unit_coord(1'b0));
    localparam logic signed [UNIT_W-1:0] SIN_K = UNIT_W'(unit_coord(1'b1));

    logic      valid_reg;
    sum_data_t data_reg;
    sum_data_t data_next;

    always_comb
    begin
        data_next = stage_in.data;
        // active-low sensor: add its vector
        if (!stage_in.data.bits[INDEX])
        begin
            data_next.sx = stage_in.data.sx + SUM_W'(COS_K);
            data_next.sy = stage_in.data.sy + SUM_W'(SIN_K);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_in.valid)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        stage_out.valid = valid_reg;
        stage_out.data  = data_reg;
    end

endmodule

### rtl/srdv_vec_cell.sv
// ----------------------------------------------------------------------------
// srdv_vec_cell: one CORDIC vectoring step and one square root digit
// Rotates (x, y) towards the x axis by atan(2^-INDEX) and settles one bit of
// the floor square root of X*X + Y*Y.
// ----------------------------------------------------------------------------
module srdv_vec_cell #(
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  srdv_pkg::vec_stage_t stage_in,
    output srdv_pkg::vec_stage_t stage_out
);
    import srdv_pkg::*;

    localparam int BIT_POS = ROOT_W - 1 - INDEX;

    logic                   valid_reg;
    vec_data_t              data_reg;
    vec_data_t              data_next;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic [SQ_W:0]          trial;

    always_comb
    begin
        dx    = stage_in.data.y >>> INDEX;
        dy    = stage_in.data.x >>> INDEX;
        // (2*root + b) * b with b = 2^BIT_POS
        trial = ((SQ_W + 1)'(stage_in.data.root) << (BIT_POS + 1))
              + ((SQ_W + 1)'(1) << (2 * BIT_POS));
        data_next = stage_in.data;
        if (!stage_in.data.y[CX_W-1])
        begin
            data_next.x = stage_in.data.x + dx;
            data_next.y = stage_in.data.y - dy;
            data_next.z = stage_in.data.z + ATAN_DEG_Q16[INDEX];
        end
        else
        begin
            data_next.x = stage_in.data.x - dx;
            data_next.y = stage_in.data.y + dy;
            data_next.z = stage_in.data.z - ATAN_DEG_Q16[INDEX];
        end
        if ({1'b0, stage_in.data.rem} >= trial)
        begin
            data_next.rem  = SQ_W'({1'b0, stage_in.data.rem} - trial);
            data_next.root = stage_in.data.root | (ROOT_W'(1) << BIT_POS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_in.valid)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        stage_out.valid = valid_reg;
        stage_out.data  = data_reg;
    end

endmodule

### rtl/sensor_ring_direction_vector_core.sv
// ----------------------------------------------------------------------------
// sensor_ring_direction_vector_core: direction and strength of a ring frame
// Pipeline: a transferred frame passes one register per sensor cell
// (min(SENSOR_COUNT,32) of them), three to fold, square and add, twenty
// CORDIC/root cells and three to finish before done. Throughput: one frame per
// cycle, set by the fully pipelined cell chains. The receiver cannot stall;
// each result shows for one cycle. Reset clears the pipeline and the
// registers (trim 5, threshold 0); busy stays high until the first edge after.
// ----------------------------------------------------------------------------
module sensor_ring_direction_vector_core #(
    parameter int SENSOR_COUNT = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic [srdv_pkg::BITS_W-1:0]                 sensor_bits,
    output logic                                        done,
    output logic signed [srdv_pkg::DIR_W-1:0]           direction_deg,
    output logic [srdv_pkg::MAG_W-1:0]                  magnitude,
    output logic                                        is_far,
    input  logic                                        cfg_write,
    input  logic [srdv_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [srdv_pkg::CFG_DATA_W-1:0]             cfg_data
);
    import srdv_pkg::*;

    // Sensors from index 32 upwards have no input bit and never count
    localparam int SUM_CELLS = (SENSOR_COUNT < BITS_W) ? SENSOR_COUNT : BITS_W;
    localparam int LATENCY   = SUM_CELLS + CORDIC_STEPS + 6;

    // ------------------------------------------------------------------
    // Configuration registers and transfer gate
    // ------------------------------------------------------------------
    logic signed [TRIM_W-1:0] angle_trim_reg;
    logic [THR_W-1:0]         far_threshold_reg;
    logic                     busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_trim_reg    <= TRIM_RESET;
            far_threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ANGLE_TRIM:    angle_trim_reg    <= cfg_data[TRIM_W-1:0];
                CFG_FAR_THRESHOLD: far_threshold_reg <= cfg_data[THR_W-1:0];
            endcase
        end
    end

    // hold off transfers until the first edge after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;

    // ------------------------------------------------------------------
    // Sensor chain: each cell adds its own unit vector
    // ------------------------------------------------------------------
    sum_stage_t sum_link [SUM_CELLS+1];

    always_comb
    begin
        sum_link[0].valid     = start && !busy_reg;
        sum_link[0].data.bits = sensor_bits;
        sum_link[0].data.sx   = '0;
        sum_link[0].data.sy   = '0;
    end

    for (genvar k = 0; k < SUM_CELLS; k++)
    begin : g_sum
        srdv_sum_cell #(
            .SENSOR_COUNT (SENSOR_COUNT),
            .INDEX        (k)
        ) u_sum_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (sum_link[k]),
            .stage_out (sum_link[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Prepare: fold into the first quadrant, classify exact angles
    // ------------------------------------------------------------------
    logic                    p1_valid_reg;
    logic [ABS_W-1:0]        p1_ax_reg;
    logic [ABS_W-1:0]        p1_ay_reg;
    logic                    p1_sxn_reg;
    logic                    p1_syn_reg;
    angle_case_t             p1_case_reg;
    logic [ABS_W-1:0]        p1_ax_next;
    logic [ABS_W-1:0]        p1_ay_next;
    angle_case_t             p1_case_next;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    always_comb
    begin
        sum_x      = sum_link[SUM_CELLS].data.sx;
        sum_y      = sum_link[SUM_CELLS].data.sy;
        p1_ax_next = ABS_W'(sum_x[SUM_W-1] ? -sum_x : sum_x);
        p1_ay_next = ABS_W'(sum_y[SUM_W-1] ? -sum_y : sum_y);
        // axes and diagonals take the exact angle instead of CORDIC
        priority if (sum_x == '0 && sum_y == '0)
        begin
            p1_case_next = ANG_ZERO;
        end
        else if (sum_y == '0)
        begin
            p1_case_next = ANG_ON_X;
        end
        else if (sum_x == '0)
        begin
            p1_case_next = ANG_ON_Y;
        end
        else if (p1_ax_next == p1_ay_next)
        begin
            p1_case_next = ANG_DIAG;
        end
        else
        begin
            p1_case_next = ANG_CORDIC;
        end
    end

    // Square both components
    logic             p2_valid_reg;
    logic [ABS_W-1:0] p2_ax_reg;
    logic [ABS_W-1:0] p2_ay_reg;
    logic             p2_sxn_reg;
    logic             p2_syn_reg;
    angle_case_t      p2_case_reg;
    logic [SQ_W-1:0]  p2_sqx_reg;
    logic [SQ_W-1:0]  p2_sqy_reg;
    logic [SQ_W-1:0]  p2_sqx_next;
    logic [SQ_W-1:0]  p2_sqy_next;

    assign p2_sqx_next = p1_ax_reg * p1_ax_reg;
    assign p2_sqy_next = p1_ay_reg * p1_ay_reg;

    // Sum of squares and CORDIC start values
    logic      p3_valid_reg;
    vec_data_t p3_data_reg;
    vec_data_t p3_data_next;

    always_comb
    begin
        p3_data_next.x      = CX_W'(p2_ax_reg) << CORDIC_PRESHIFT;
        p3_data_next.y      = CX_W'(p2_ay_reg) << CORDIC_PRESHIFT;
        p3_data_next.z      = '0;
        p3_data_next.rem    = p2_sqx_reg + p2_sqy_reg;
        p3_data_next.root   = '0;
        p3_data_next.sx_neg = p2_sxn_reg;
        p3_data_next.sy_neg = p2_syn_reg;
        p3_data_next.acase  = p2_case_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= sum_link[SUM_CELLS].valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_link[SUM_CELLS].valid)
        begin
            p1_ax_reg   <= p1_ax_next;
            p1_ay_reg   <= p1_ay_next;
            p1_sxn_reg  <= sum_x[SUM_W-1];
            p1_syn_reg  <= sum_y[SUM_W-1];
            p1_case_reg <= p1_case_next;
        end
        if (p1_valid_reg)
        begin
            p2_ax_reg   <= p1_ax_reg;
            p2_ay_reg   <= p1_ay_reg;
            p2_sxn_reg  <= p1_sxn_reg;
            p2_syn_reg  <= p1_syn_reg;
            p2_case_reg <= p1_case_reg;
            p2_sqx_reg  <= p2_sqx_next;
            p2_sqy_reg  <= p2_sqy_next;
        end
        if (p2_valid_reg)
        begin
            p3_data_reg <= p3_data_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC and square root chain
    // ------------------------------------------------------------------
    vec_stage_t vec_link [CORDIC_STEPS+1];

    always_comb
    begin
        vec_link[0].valid = p3_valid_reg;
        vec_link[0].data  = p3_data_reg;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        srdv_vec_cell #(
            .INDEX (i)
        ) u_vec_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (vec_link[i]),
            .stage_out (vec_link[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Finish 1: first-quadrant angle and scaled magnitude
    // ------------------------------------------------------------------
    vec_data_t               vec_out;
    logic                    f1_valid_reg;
    logic signed [Z_W-1:0]   f1_phi_reg;
    logic signed [Z_W-1:0]   f1_phi_next;
    logic [MAG_W-1:0]        f1_mag_reg;
    logic [MAG_W-1:0]        f1_mag_next;
    logic [ROOT_W-1:0]       root_scaled;
    logic                    f1_sxn_reg;
    logic                    f1_syn_reg;

    always_comb
    begin
        vec_out = vec_link[CORDIC_STEPS].data;
        unique case (vec_out.acase)
            ANG_ZERO:   f1_phi_next = '0;
            ANG_ON_X:   f1_phi_next = '0;
            ANG_ON_Y:   f1_phi_next = DEG90_Q16;
            ANG_DIAG:   f1_phi_next = DEG45_Q16;
            ANG_CORDIC:
            begin
                // clamp the residual CORDIC error into 0..90 degrees
                if (vec_out.z[Z_W-1])
                begin
                    f1_phi_next = '0;
                end
                else if (vec_out.z > DEG90_Q16)
                begin
                    f1_phi_next = DEG90_Q16;
                end
                else
                begin
                    f1_phi_next = vec_out.z;
                end
            end
            default:    f1_phi_next = '0;
        endcase
        // Q14 length to Q8, saturate
        root_scaled = vec_out.root >> MAG_SHIFT;
        if (root_scaled > ROOT_W'(MAG_MAX))
        begin
            f1_mag_next = MAG_MAX;
        end
        else
        begin
            f1_mag_next = root_scaled[MAG_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Finish 2: trim minus signed angle, degrees Q16
    // ------------------------------------------------------------------
    logic                   f2_valid_reg;
    logic signed [V_W-1:0]  f2_v_reg;
    logic signed [V_W-1:0]  f2_v_next;
    logic [MAG_W-1:0]       f2_mag_reg;
    logic signed [Z_W-1:0]  theta_abs;

    always_comb
    begin
        theta_abs = f1_sxn_reg ? (DEG180_Q16 - f1_phi_reg) : f1_phi_reg;
        // lower half plane: angle is negative, so add it back
        f2_v_next = (V_W'(angle_trim_reg) <<< FRAC_SHIFT)
                  + (f1_syn_reg ? V_W'(theta_abs) : -V_W'(theta_abs));
    end

    // ------------------------------------------------------------------
    // Finish 3: truncate towards zero, wrap, compare with threshold
    // ------------------------------------------------------------------
    logic signed [V_W-1:0]   v_bias;
    logic signed [DEG_W-1:0] deg_trunc;
    logic signed [DEG_W-1:0] deg_wrap;
    logic                    done_reg;
    logic signed [DIR_W-1:0] direction_reg;
    logic [MAG_W-1:0]        magnitude_reg;
    logic                    is_far_reg;

    always_comb
    begin
        v_bias    = f2_v_reg + (f2_v_reg[V_W-1] ? FRAC_MASK : '0);
        deg_trunc = DEG_W'(v_bias >>> FRAC_SHIFT);
        if (deg_trunc > DIR_LIMIT)
        begin
            deg_wrap = deg_trunc - DEG_TURN;
        end
        else if (deg_trunc < -DIR_LIMIT)
        begin
            deg_wrap = deg_trunc + DEG_TURN;
        end
        else
        begin
            deg_wrap = deg_trunc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= vec_link[CORDIC_STEPS].valid;
            f2_valid_reg <= f1_valid_reg;
            done_reg     <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vec_link[CORDIC_STEPS].valid)
        begin
            f1_phi_reg <= f1_phi_next;
            f1_mag_reg <= f1_mag_next;
            f1_sxn_reg <= vec_out.sx_neg;
            f1_syn_reg <= vec_out.sy_neg;
        end
        if (f1_valid_reg)
        begin
            f2_v_reg   <= f2_v_next;
            f2_mag_reg <= f1_mag_reg;
        end
        if (f2_valid_reg)
        begin
            direction_reg <= DIR_W'(deg_wrap);
            magnitude_reg <= f2_mag_reg;
            is_far_reg    <= (f2_mag_reg < far_threshold_reg);
        end
    end

    assign done          = done_reg;
    assign direction_deg = direction_reg;
    assign magnitude     = magnitude_reg;
    assign is_far        = is_far_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("frame transfer without result at pipeline latency");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without matching frame transfer");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((direction_deg >= -DIR_W'(180)) && (direction_deg <= DIR_W'(180))))
        else $error("direction outside the wrapped range");

    a_far_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_far == (magnitude < far_threshold_reg)))
        else $error("far flag disagrees with magnitude and threshold");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sensor_ring_direction_vector_core
// Feeds ring frames through the start/busy handshake, predicts heading,
// strength and far flag of every frame, and checks each done strobe in order.
// Directed frames come first, then random frames over several trim and
// threshold settings, with random gaps on the sender side.
// ----------------------------------------------------------------------------
module tb;

    localparam int RING_SIZE      = 32;
    localparam int WATCHDOG_LIMIT = 2000;   // well above latency plus longest gap
    localparam int DRAIN_CYCLES   = 80;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_FRAMES   = 204;
    localparam int MAX_REPORTS    = 10;

    localparam longint unsigned Q30_UNIT = 64'd1073741824;
    localparam longint unsigned PI_Q30V  = 64'd3373259426;
    localparam longint          DEG_ONE  = 65536;       // one degree in Q16
    localparam int              ROT_STEPS = 20;

    // atan(2^-i) in degrees Q16, one entry per rotation
    localparam longint ROT_ANGLE [ROT_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234378, 117303, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct packed {
        logic signed [srdv_pkg::DIR_W-1:0] dir;
        logic [srdv_pkg::MAG_W-1:0]        mag;
        logic                              far;
    } heading_t;

    // One directed frame; the heading is typed in only where it is obvious
    typedef struct packed {
        logic [srdv_pkg::BITS_W-1:0] bits;
        logic                        typed;
        heading_t                    want;
    } frame_row_t;

    localparam int ROW_COUNT = 23;
    localparam frame_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        // no sensor active: heading is the trim, no strength
        '{32'hFFFF_FFFF, 1'b1, '{9'sd5, 12'd0, 1'b0}},
        // whole ring active: sums cancel exactly
        '{32'h0000_0000, 1'b1, '{9'sd5, 12'd0, 1'b0}},
        // single sensors on the axes
        '{32'hFFFF_FFFE, 1'b1, '{9'sd5, 12'd256, 1'b0}},
        '{32'hFFFF_FEFF, 1'b1, '{-9'sd85, 12'd256, 1'b0}},
        '{32'hFFFE_FFFF, 1'b1, '{-9'sd175, 12'd256, 1'b0}},
        '{32'hFEFF_FFFF, 1'b1, '{9'sd95, 12'd256, 1'b0}},
        // opposite pair cancels
        '{32'hFFFE_FFFE, 1'b1, '{9'sd5, 12'd0, 1'b0}},
        // diagonals
        '{32'hFFFF_FFEF, 1'b0, '0},
        '{32'hFFFF_EFFF, 1'b0, '0},
        '{32'hFFEF_FFFF, 1'b0, '0},
        '{32'hEFFF_FFFF, 1'b0, '0},
        // off-axis sensors go through the rotations
        '{32'hFFFF_FFFD, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, '0},
        '{32'hFFFF_0000, 1'b0, '0},
        '{32'h0000_FFFF, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'hFFFF_FFFC, 1'b0, '0},
        '{32'hFFFF_FEEF, 1'b0, '0},
        '{32'hFFFF_FF00, 1'b0, '0},
        '{32'h00FF_FFFF, 1'b0, '0},
        '{32'h1234_5678, 1'b0, '0},
        '{32'hFEDC_BA98, 1'b0, '0}
    };

    // Fixed register settings at the extremes; later phases pick at random
    localparam int FIXED_PHASES = 5;
    localparam int PHASE_TRIM [FIXED_PHASES] = '{180, -180, 255, -256, 0};
    localparam int PHASE_THR  [FIXED_PHASES] = '{4095, 0, 1, 2600, 256};

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic [srdv_pkg::BITS_W-1:0]         sensor_bits;
    logic                                done;
    logic signed [srdv_pkg::DIR_W-1:0]   direction_deg;
    logic [srdv_pkg::MAG_W-1:0]          magnitude;
    logic                                is_far;
    logic                                cfg_write;
    logic [srdv_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [srdv_pkg::CFG_DATA_W-1:0]     cfg_data;

    // Bench copies of the two registers
    logic [srdv_pkg::TRIM_W-1:0] trim_cfg;
    logic [srdv_pkg::THR_W-1:0]  thr_cfg;

    // Unit vector of every sensor, Q1.14
    longint ring_cos [RING_SIZE];
    longint ring_sin [RING_SIZE];

    heading_t heading_q [$];

    int frames_sent;
    int results_seen;
    int settings_used;
    int mismatch_count;

    sensor_ring_direction_vector_core #(
        .SENSOR_COUNT (RING_SIZE)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sensor_bits   (sensor_bits),
        .done          (done),
        .direction_deg (direction_deg),
        .magnitude     (magnitude),
        .is_far        (is_far),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Build the sensor vectors: fold each angle to within 45 degrees of an
    // axis, run the sine and cosine series in Q30, round to Q1.14, unfold.
    function automatic void build_ring();
        longint            q, m, si, ci;
        longint unsigned   am, x, u, t, s, c;
        longint unsigned   sin_div [5] = '{110, 72, 42, 20, 6};
        longint unsigned   cos_div [5] = '{132, 90, 56, 30, 12};
        for (int k = 0; k < RING_SIZE; k++)
        begin
            q  = (8 * k + RING_SIZE) / (2 * RING_SIZE);
            m  = 4 * k - q * RING_SIZE;
            am = (m < 0) ? -m : m;
            x  = PI_Q30V * am / (2 * RING_SIZE);
            u  = (x * x) >> 30;
            t  = Q30_UNIT;
            for (int i = 0; i < 5; i++)
                t = Q30_UNIT - ((u * t) >> 30) / sin_div[i];
            s = (x * t) >> 30;
            t = Q30_UNIT;
            for (int i = 0; i < 5; i++)
                t = Q30_UNIT - ((u * t) >> 30) / cos_div[i];
            c  = Q30_UNIT - ((u * t) >> 30) / 2;
            si = longint'((s + 32768) >> 16);
            ci = longint'((c + 32768) >> 16);
            if (m < 0)
                si = -si;
            case (q & 3)
                0:       begin ring_cos[k] = ci;  ring_sin[k] = si;  end
                1:       begin ring_cos[k] = -si; ring_sin[k] = ci;  end
                2:       begin ring_cos[k] = -ci; ring_sin[k] = -si; end
                default: begin ring_cos[k] = si;  ring_sin[k] = -ci; end
            endcase
        end
    endfunction

    // First-quadrant angle in degrees Q16; axes and diagonal are exact
    function automatic longint quadrant_angle(longint ax, longint ay);
        longint x, y, z, dx, dy;
        if (ay == 0)
            return 0;
        if (ax == 0)
            return 90 * DEG_ONE;
        if (ax == ay)
            return 45 * DEG_ONE;
        x = ax * 1024;
        y = ay * 1024;
        z = 0;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ROT_ANGLE[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ROT_ANGLE[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > 90 * DEG_ONE)
            z = 90 * DEG_ONE;
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r  = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Heading, strength and far flag of one frame under the current registers
    function automatic heading_t heading_of(logic [srdv_pkg::BITS_W-1:0] bits);
        heading_t        h;
        longint          sx, sy, ax, ay, phi, theta, trim, v, deg;
        longint unsigned mag;
        sx = 0;
        sy = 0;
        for (int k = 0; k < RING_SIZE; k++)
        begin
            if (k < 32 && !bits[k])
            begin
                sx += ring_cos[k];
                sy += ring_sin[k];
            end
        end
        theta = 0;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        if (sx != 0 || sy != 0)
        begin
            phi = quadrant_angle(ax, ay);
            if (sx < 0)
                phi = 180 * DEG_ONE - phi;
            theta = (sy < 0) ? -phi : phi;
        end
        trim = longint'($signed(trim_cfg));
        v    = trim * DEG_ONE - theta;
        deg  = v / DEG_ONE;                 // truncates toward zero
        while (deg > 180)
            deg -= 360;
        while (deg < -180)
            deg += 360;
        mag = floor_sqrt(longint'(ax * ax) + longint'(ay * ay)) >> 6;
        if (mag > 4095)
            mag = 4095;
        h.dir = deg[srdv_pkg::DIR_W-1:0];
        h.mag = mag[srdv_pkg::MAG_W-1:0];
        h.far = (mag < longint'(thr_cfg));
        return h;
    endfunction

    // A mix of random, sparse and arc-shaped frames; the last two give strong vectors
    function automatic logic [srdv_pkg::BITS_W-1:0] random_frame();
        logic [srdv_pkg::BITS_W-1:0] b;
        logic [63:0]                 arc;
        int                          sel, n, pos, len;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            b = $urandom;
        else if (sel < 70)
        begin
            b = '1;
            n = $urandom_range(1, 4);
            repeat (n)
                b[$urandom_range(0, 31)] = 1'b0;
        end
        else if (sel < 90)
        begin
            pos = $urandom_range(0, 31);
            len = $urandom_range(1, 31);
            arc = ((64'd1 << len) - 1) << pos;
            b   = ~(arc[31:0] | arc[63:32]);
        end
        else if (sel < 95)
            b = '1;
        else
        begin
            b = '0;
            n = $urandom_range(1, 3);
            repeat (n)
                b[$urandom_range(0, 31)] = 1'b1;
        end
        return b;
    endfunction

    // Offer one frame and hold it until the transfer edge
    task automatic send_frame(input logic [srdv_pkg::BITS_W-1:0] bits, input heading_t want);
        start       <= 1'b1;
        sensor_bits <= bits;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        heading_q.push_back(want);
        frames_sent++;
    endtask

    // Drop start for a random burst, with noise on the frame bus
    task automatic sender_gap();
        start       <= 1'b0;
        sensor_bits <= $urandom;
        repeat ($urandom_range(1, 10))
            @(posedge clk);
    endtask

    // Drop start and wait until every frame in flight has come back
    task automatic settle();
        start <= 1'b0;
        while (heading_q.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers; only called with the pipeline empty.
    // Upper bits of the trim word are junk and must be ignored.
    task automatic configure(input logic [srdv_pkg::TRIM_W-1:0] trim,
                             input logic [srdv_pkg::THR_W-1:0] thr);
        cfg_write <= 1'b1;
        cfg_index <= srdv_pkg::CFG_ANGLE_TRIM;
        cfg_data  <= {3'($urandom), trim};
        @(posedge clk);
        cfg_index <= srdv_pkg::CFG_FAR_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_write <= 1'b0;
        trim_cfg  = trim;
        thr_cfg   = thr;
        settings_used++;
    endtask

    // Compare every done strobe with the oldest prediction
    always @(posedge clk)
    begin : check_result
        heading_t want;
        if (rst_n && done)
        begin
            if (heading_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: dir %0d mag %0d far %0b",
                             direction_deg, magnitude, is_far);
            end
            else
            begin
                want = heading_q.pop_front();
                results_seen++;
                if (direction_deg !== want.dir || magnitude !== want.mag ||
                    is_far !== want.far)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result %0d: dir %0d/%0d mag %0d/%0d far %0b/%0b (got/want)",
                                 results_seen, direction_deg, want.dir,
                                 magnitude, want.mag, is_far, want.far);
                end
            end
        end
    end

    // Watchdog: end the run if nothing has been transferred for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("sensor_ring_direction_vector_core test failed");
        $finish;
    end

    initial
    begin : stimulus
        heading_t                    want;
        logic [srdv_pkg::BITS_W-1:0] bits;
        logic [srdv_pkg::TRIM_W-1:0] trim;
        logic [srdv_pkg::THR_W-1:0]  thr;

        frames_sent    = 0;
        results_seen   = 0;
        settings_used  = 0;
        mismatch_count = 0;
        trim_cfg       = 9'd5;
        thr_cfg        = '0;
        build_ring();

        rst_n       <= 1'b0;
        start       <= 1'b0;
        sensor_bits <= '0;
        cfg_write   <= 1'b0;
        cfg_index   <= srdv_pkg::CFG_ANGLE_TRIM;
        cfg_data    <= '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset values of the registers
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            want = DIRECTED_ROWS[r].typed ? DIRECTED_ROWS[r].want
                                          : heading_of(DIRECTED_ROWS[r].bits);
            send_frame(DIRECTED_ROWS[r].bits, want);
            if ($urandom_range(0, 3) == 0)
                sender_gap();
        end
        settle();

        // Random frames, one register setting per phase; no gaps in the last
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p < FIXED_PHASES)
            begin
                trim = PHASE_TRIM[p][srdv_pkg::TRIM_W-1:0];
                thr  = PHASE_THR[p][srdv_pkg::THR_W-1:0];
            end
            else
            begin
                trim = $urandom_range(0, 511);
                thr  = $urandom_range(0, 2700);
            end
            configure(trim, thr);
            for (int n = 0; n < PHASE_FRAMES; n++)
            begin
                bits = random_frame();
                send_frame(bits, heading_of(bits));
                if (p != PHASE_COUNT - 1 && $urandom_range(0, 99) < 30)
                    sender_gap();
            end
            settle();
        end

        // Hold a little longer to catch stray strobes
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d frames sent over %0d register settings plus reset values",
                 frames_sent, settings_used);
        $display("%0d results compared, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0 && heading_q.size() == 0)
            $display("sensor_ring_direction_vector_core test passed");
        else
            $display("sensor_ring_direction_vector_core test failed");
        $finish;
    end

endmodule
